[hdl/dtu_pkg.sv]
// ----------------------------------------------------------------------------
// dtu_pkg: shared definitions for the device table
// Table size, field widths, request and outcome codes and the stored entry
// layout used by the table controller, its checker and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package dtu_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   // word field widths
   localparam int KEY_W  = 48;
   localparam int STR_W  = 8;
   localparam int SEEN_W = 32;
   localparam int SLOT_W = 4;
   localparam int OUT_W  = 3;
   localparam int FILL_W = 5;

   // width used to compare a read index against the fill count
   localparam int RIDX_CMP_W = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

   localparam logic [CNT_W-1:0]  COUNT_FULL = CNT_W'(TABLE_ENTRIES);
   localparam logic [SEEN_W-1:0] SEEN_MAX   = '1;

   // request codes
   localparam logic REQ_UPSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   // outcome codes
   localparam logic [OUT_W-1:0] OUT_UPDATED     = 3'd0;
   localparam logic [OUT_W-1:0] OUT_INSERTED    = 3'd1;
   localparam logic [OUT_W-1:0] OUT_EVICTED     = 3'd2;
   localparam logic [OUT_W-1:0] OUT_READ_OK     = 3'd3;
   localparam logic [OUT_W-1:0] OUT_READ_BEYOND = 3'd4;

   // one stored table entry
   typedef struct packed {
      logic [KEY_W-1:0]         key;
      logic signed [STR_W-1:0]  strength;
      logic [SEEN_W-1:0]        seen;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

[hdl/device_table_upsert_oldest_evict.sv]
// ----------------------------------------------------------------------------
// device_table_upsert_oldest_evict: bounded table of seen devices
// Upsert keyed by device id with oldest-seen replacement when full, and
// indexed reads returning an entry together with the fill count.
// ----------------------------------------------------------------------------
// Upsert: a nonempty table is walked in ST_SCAN, a key match ending the walk early; then
//   ST_WRITE writes the entry. An empty table goes straight from idle to ST_WRITE.
//   The walk reads one entry per cycle through the RAM read port into one shared compare.
// Read in range: RAM read register, then result register; beyond count: strobe next cycle.
// busy is high until the strobe (never for reads beyond count); a new word is taken then.
// Reset returns to idle and clears the fill count; entry storage is not cleared.
`default_nettype none

module device_table_upsert_oldest_evict (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_type,
   input  wire logic [dtu_pkg::KEY_W-1:0]      req_dev_id,
   input  wire logic signed [dtu_pkg::STR_W-1:0] req_sig_strength,
   input  wire logic [dtu_pkg::SEEN_W-1:0]     req_now_time,
   input  wire logic [dtu_pkg::SLOT_W-1:0]     req_read_index,
   output logic                                rsp_valid,
   output logic [dtu_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [dtu_pkg::OUT_W-1:0]           rsp_outcome,
   output logic [dtu_pkg::FILL_W-1:0]          rsp_fill_count,
   output logic [dtu_pkg::KEY_W-1:0]           rsp_entry_key,
   output logic signed [dtu_pkg::STR_W-1:0]    rsp_entry_strength,
   output logic [dtu_pkg::SEEN_W-1:0]          rsp_entry_seen
);

   import dtu_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_SCAN      = 2'd1;
   localparam logic [1:0] ST_WRITE     = 2'd2;
   localparam logic [1:0] ST_READ_WAIT = 2'd3;

   // control registers
   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              iss_act_ff, iss_act_in;
   logic              chk_vld_ff, chk_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [KEY_W-1:0]         key_ff, key_in;
   logic signed [STR_W-1:0]  str_ff, str_in;
   logic [SEEN_W-1:0]        now_ff, now_in;
   logic [IDX_W-1:0]         iss_idx_ff, iss_idx_in;
   logic [IDX_W-1:0]         chk_idx_ff, chk_idx_in;
   logic [SEEN_W-1:0]        old_seen_ff, old_seen_in;
   logic [IDX_W-1:0]         old_idx_ff, old_idx_in;
   logic [IDX_W-1:0]         slot_idx_ff, slot_idx_in;
   logic [OUT_W-1:0]         outcome_ff, outcome_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [OUT_W-1:0]         rsp_outcome_ff, rsp_outcome_in;
   logic [FILL_W-1:0]        rsp_fill_ff, rsp_fill_in;
   logic [KEY_W-1:0]         rsp_key_ff, rsp_key_in;
   logic signed [STR_W-1:0]  rsp_str_ff, rsp_str_in;
   logic [SEEN_W-1:0]        rsp_seen_ff, rsp_seen_in;

   // storage port signals
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]  rd_data;
   logic                wr_en;
   entry_type           wr_entry;
   entry_type           rd_entry;

   // shared compare unit and helpers
   logic              accept;
   logic              ridx_ok;
   logic [IDX_W-1:0]  last_idx;
   logic              key_hit;
   logic              older;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign ridx_ok  = RIDX_CMP_W'(req_read_index) < RIDX_CMP_W'(count_ff);
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign rd_entry = entry_type'(rd_data);
   assign key_hit  = (rd_entry.key == key_ff);
   assign older    = (rd_entry.seen < old_seen_ff);
   assign wr_entry = '{key: key_ff, strength: str_ff, seen: now_ff};

   // table storage
   dtu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_idx_ff),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      iss_act_in     = iss_act_ff;
      chk_vld_in     = chk_vld_ff;
      key_in         = key_ff;
      str_in         = str_ff;
      now_in         = now_ff;
      iss_idx_in     = iss_idx_ff;
      chk_idx_in     = chk_idx_ff;
      old_seen_in    = old_seen_ff;
      old_idx_in     = old_idx_ff;
      slot_idx_in    = slot_idx_ff;
      outcome_in     = outcome_ff;
      rsp_valid_in   = 1'b0;
      rsp_slot_in    = rsp_slot_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_fill_in    = rsp_fill_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_str_in     = rsp_str_ff;
      rsp_seen_in    = rsp_seen_ff;
      rd_en          = 1'b0;
      rd_addr        = iss_idx_ff;
      wr_en          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_READ) begin
                  rsp_slot_in = req_read_index;
                  if (ridx_ok) begin
                     rd_en    = 1'b1;
                     rd_addr  = IDX_W'(req_read_index);
                     state_in = ST_READ_WAIT;
                  end else begin
                     // index at or past the fill count: empty entry fields
                     rsp_valid_in   = 1'b1;
                     rsp_outcome_in = OUT_READ_BEYOND;
                     rsp_fill_in    = FILL_W'(count_ff);
                     rsp_key_in     = '0;
                     rsp_str_in     = '0;
                     rsp_seen_in    = '0;
                  end
               end else begin
                  key_in = req_dev_id;
                  str_in = req_sig_strength;
                  now_in = req_now_time;
                  if (count_ff == '0) begin
                     slot_idx_in = '0;
                     outcome_in  = OUT_INSERTED;
                     state_in    = ST_WRITE;
                  end else begin
                     iss_idx_in  = '0;
                     iss_act_in  = 1'b1;
                     chk_vld_in  = 1'b0;
                     old_seen_in = SEEN_MAX;
                     old_idx_in  = '0;
                     state_in    = ST_SCAN;
                  end
               end
            end
         end

         ST_SCAN: begin
            // issue side: one entry read per cycle
            if (iss_act_ff) begin
               rd_en = 1'b1;
               if (iss_idx_ff == last_idx) begin
                  iss_act_in = 1'b0;
               end else begin
                  iss_idx_in = iss_idx_ff + IDX_W'(1);
               end
            end
            chk_vld_in = iss_act_ff;
            chk_idx_in = iss_idx_ff;

            // check side: compare the entry read last cycle
            if (chk_vld_ff) begin
               if (key_hit) begin
                  slot_idx_in = chk_idx_ff;
                  outcome_in  = OUT_UPDATED;
                  iss_act_in  = 1'b0;
                  chk_vld_in  = 1'b0;
                  state_in    = ST_WRITE;
               end else begin
                  // strict compare keeps the lowest index on a tie
                  if (older) begin
                     old_seen_in = rd_entry.seen;
                     old_idx_in  = chk_idx_ff;
                  end
                  if (chk_idx_ff == last_idx) begin
                     state_in = ST_WRITE;
                     if (count_ff < COUNT_FULL) begin
                        slot_idx_in = IDX_W'(count_ff);
                        outcome_in  = OUT_INSERTED;
                     end else begin
                        slot_idx_in = older ? chk_idx_ff : old_idx_ff;
                        outcome_in  = OUT_EVICTED;
                     end
                  end
               end
            end
         end

         ST_WRITE: begin
            wr_en = 1'b1;
            if (outcome_ff == OUT_INSERTED) begin
               count_in = count_ff + CNT_W'(1);
            end
            rsp_valid_in   = 1'b1;
            rsp_slot_in    = SLOT_W'(slot_idx_ff);
            rsp_outcome_in = outcome_ff;
            rsp_fill_in    = FILL_W'(count_in);
            rsp_key_in     = key_ff;
            rsp_str_in     = str_ff;
            rsp_seen_in    = now_ff;
            state_in       = ST_IDLE;
         end

         ST_READ_WAIT: begin
            rsp_valid_in   = 1'b1;
            rsp_outcome_in = OUT_READ_OK;
            rsp_fill_in    = FILL_W'(count_ff);
            rsp_key_in     = rd_entry.key;
            rsp_str_in     = rd_entry.strength;
            rsp_seen_in    = rd_entry.seen;
            state_in       = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         iss_act_ff   <= 1'b0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_act_ff   <= iss_act_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      str_ff         <= str_in;
      now_ff         <= now_in;
      iss_idx_ff     <= iss_idx_in;
      chk_idx_ff     <= chk_idx_in;
      old_seen_ff    <= old_seen_in;
      old_idx_ff     <= old_idx_in;
      slot_idx_ff    <= slot_idx_in;
      outcome_ff     <= outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_fill_ff    <= rsp_fill_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_str_ff     <= rsp_str_in;
      rsp_seen_ff    <= rsp_seen_in;
   end

   // result word
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_outcome        = rsp_outcome_ff;
   assign rsp_fill_count     = rsp_fill_ff;
   assign rsp_entry_key      = rsp_key_ff;
   assign rsp_entry_strength = rsp_str_ff;
   assign rsp_entry_seen     = rsp_seen_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("fill count above table size");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff)))
         |-> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("fill count moved by other than one");

   a_upsert_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_UPSERT)) |=> busy)
      else $error("upsert accepted without going busy");

   a_check_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> ((state_ff == ST_SCAN) && (chk_idx_ff <= last_idx)))
      else $error("compare outside the filled range");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_outcome_ff == OUT_EVICTED)) |-> (count_ff == COUNT_FULL))
      else $error("eviction with free slots left");

endmodule

`default_nettype wire

[hdl/dtu_ram.sv]
// ----------------------------------------------------------------------------
// dtu_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module dtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[sim/device_table_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// device_table_checker: result prediction and compare for the device table
// Keeps a shadow copy of the table that follows every accepted request word.
// The expected response of each word is queued and matched, field by field,
// against the responses strobed out by the table in order.
// ----------------------------------------------------------------------------

module device_table_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic                             busy,
   input  wire logic                             req_type,
   input  wire logic [dtu_pkg::KEY_W-1:0]        req_dev_id,
   input  wire logic signed [dtu_pkg::STR_W-1:0] req_sig_strength,
   input  wire logic [dtu_pkg::SEEN_W-1:0]       req_now_time,
   input  wire logic [dtu_pkg::SLOT_W-1:0]       req_read_index,
   input  wire logic                             rsp_valid,
   input  wire logic [dtu_pkg::SLOT_W-1:0]       rsp_slot,
   input  wire logic [dtu_pkg::OUT_W-1:0]        rsp_outcome,
   input  wire logic [dtu_pkg::FILL_W-1:0]       rsp_fill_count,
   input  wire logic [dtu_pkg::KEY_W-1:0]        rsp_entry_key,
   input  wire logic signed [dtu_pkg::STR_W-1:0] rsp_entry_strength,
   input  wire logic [dtu_pkg::SEEN_W-1:0]       rsp_entry_seen,
   output int                                    fail_count,
   output int                                    open_count
);
   import dtu_pkg::*;

   // one response word as the table reports it
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [OUT_W-1:0]  outcome;
      logic [FILL_W-1:0] fill;
      entry_type         entry;
   } table_word_type;

   entry_type      shadow [TABLE_ENTRIES];
   int             shadow_fill;
   table_word_type expected_q [$];
   table_word_type want;
   table_word_type got;

   // apply one request word to the shadow table, return its response
   function automatic table_word_type apply_word(
         input logic                     kind,
         input logic [KEY_W-1:0]         id,
         input logic signed [STR_W-1:0]  strength,
         input logic [SEEN_W-1:0]        now,
         input logic [SLOT_W-1:0]        idx);
      table_word_type    w;
      int                hit;
      int                oldest;
      logic [SEEN_W-1:0] oldest_seen;
      w = '0;
      if (kind == REQ_READ) begin
         w.slot = idx;
         if (int'(idx) < shadow_fill) begin
            w.outcome = OUT_READ_OK;
            w.entry = shadow[idx];
         end else begin
            w.outcome = OUT_READ_BEYOND;
         end
         w.fill = FILL_W'(shadow_fill);
         return w;
      end
      // walk filled entries: first key match wins, else track oldest seen
      hit = -1;
      oldest = 0;
      oldest_seen = SEEN_MAX;
      for (int i = 0; i < shadow_fill; i++) begin
         if (hit < 0) begin
            if (shadow[i].key == id) begin
               hit = i;
            end else if (shadow[i].seen < oldest_seen) begin
               oldest_seen = shadow[i].seen;
               oldest = i;
            end
         end
      end
      if (hit >= 0) begin
         w.outcome = OUT_UPDATED;
         w.slot = SLOT_W'(hit);
      end else if (shadow_fill < TABLE_ENTRIES) begin
         w.outcome = OUT_INSERTED;
         w.slot = SLOT_W'(shadow_fill);
         shadow_fill++;
      end else begin
         // full table: strict compare keeps the lowest index on a tie
         w.outcome = OUT_EVICTED;
         w.slot = SLOT_W'(oldest);
      end
      shadow[w.slot].key = id;
      shadow[w.slot].strength = strength;
      shadow[w.slot].seen = now;
      w.entry = shadow[w.slot];
      w.fill = FILL_W'(shadow_fill);
      return w;
   endfunction

   // response compare first, then capture of a word taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         expected_q.delete();
         shadow_fill = 0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            shadow[i] = '0;
         end
         fail_count = 0;
         open_count <= 0;
      end else begin
         if (rsp_valid) begin
            got.slot = rsp_slot;
            got.outcome = rsp_outcome;
            got.fill = rsp_fill_count;
            got.entry.key = rsp_entry_key;
            got.entry.strength = rsp_entry_strength;
            got.entry.seen = rsp_entry_seen;
            if (expected_q.size() == 0) begin
               if (fail_count < 10) begin
                  $display("%t: unexpected response slot %0d outcome %0d fill %0d",
                           $realtime, got.slot, got.outcome, got.fill);
               end
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.slot !== want.slot || got.outcome !== want.outcome ||
                   got.fill !== want.fill || got.entry.key !== want.entry.key ||
                   got.entry.strength !== want.entry.strength ||
                   got.entry.seen !== want.entry.seen) begin
                  if (fail_count < 10) begin
                     $display("%t: mismatch exp slot %0d outcome %0d fill %0d",
                              $realtime, want.slot, want.outcome, want.fill,
                              " key %h str %0d seen %h",
                              want.entry.key, want.entry.strength, want.entry.seen);
                     $display("%t:          got slot %0d outcome %0d fill %0d",
                              $realtime, got.slot, got.outcome, got.fill,
                              " key %h str %0d seen %h",
                              got.entry.key, got.entry.strength, got.entry.seen);
                  end
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            expected_q.push_back(apply_word(req_type, req_dev_id, req_sig_strength,
                                            req_now_time, req_read_index));
         end
         open_count <= expected_q.size();
      end
   end

endmodule

[sim/device_table_upsert_oldest_evict_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// device_table_upsert_oldest_evict_test: testbench for the device table
// Drives a directed sequence (empty reads, inserts, in-place update, fill to
// capacity, eviction on an all-max timestamp tie) and then random sightings
// over a small key pool with reads mixed in, with random gaps between words.
// The checker beside the table predicts and compares every response.
// ----------------------------------------------------------------------------

module device_table_upsert_oldest_evict_test;
   import dtu_pkg::*;

   localparam int RANDOM_WORDS = 450;
   localparam int POOL_SIZE    = 24;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 30;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_type;
   logic [KEY_W-1:0]         req_dev_id;
   logic signed [STR_W-1:0]  req_sig_strength;
   logic [SEEN_W-1:0]        req_now_time;
   logic [SLOT_W-1:0]        req_read_index;
   logic                     rsp_valid;
   logic [SLOT_W-1:0]        rsp_slot;
   logic [OUT_W-1:0]         rsp_outcome;
   logic [FILL_W-1:0]        rsp_fill_count;
   logic [KEY_W-1:0]         rsp_entry_key;
   logic signed [STR_W-1:0]  rsp_entry_strength;
   logic [SEEN_W-1:0]        rsp_entry_seen;

   int                       fail_count;
   int                       open_count;
   int                       cycle_count = 0;
   bit                       burst = 1'b0;
   logic [KEY_W-1:0]         key_pool [POOL_SIZE];
   logic [SEEN_W-1:0]        clock_ms;

   device_table_upsert_oldest_evict uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_dev_id         (req_dev_id),
      .req_sig_strength   (req_sig_strength),
      .req_now_time       (req_now_time),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_slot           (rsp_slot),
      .rsp_outcome        (rsp_outcome),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_entry_key      (rsp_entry_key),
      .rsp_entry_strength (rsp_entry_strength),
      .rsp_entry_seen     (rsp_entry_seen)
   );

   device_table_checker tbl_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_dev_id         (req_dev_id),
      .req_sig_strength   (req_sig_strength),
      .req_now_time       (req_now_time),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_slot           (rsp_slot),
      .rsp_outcome        (rsp_outcome),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_entry_key      (rsp_entry_key),
      .rsp_entry_strength (rsp_entry_strength),
      .rsp_entry_seen     (rsp_entry_seen),
      .fail_count         (fail_count),
      .open_count         (open_count)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** device_table_upsert_oldest_evict: FAILED **");
         $finish;
      end
   end

   function automatic logic [KEY_W-1:0] random_key();
      return KEY_W'({$urandom, $urandom});
   endfunction

   // idle cycles ahead of a word: mostly none or short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (burst || roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // present one request word and hold it until the table takes it
   task automatic send_word(
         input logic                     kind,
         input logic [KEY_W-1:0]         id,
         input logic signed [STR_W-1:0]  strength,
         input logic [SEEN_W-1:0]        now,
         input logic [SLOT_W-1:0]        idx);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_type         <= kind;
      req_dev_id       <= id;
      req_sig_strength <= strength;
      req_now_time     <= now;
      req_read_index   <= idx;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      int                      roll;
      logic signed [STR_W-1:0] strength;
      logic [SEEN_W-1:0]       now;
      logic [SLOT_W-1:0]       idx;

      reset            = 1'b1;
      start            = 1'b0;
      req_type         = REQ_UPSERT;
      req_dev_id       = '0;
      req_sig_strength = '0;
      req_now_time     = '0;
      req_read_index   = '0;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = random_key();
      end
      clock_ms = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty table reads, extreme inserts, update in place
      send_word(REQ_READ, '0, '0, '0, 4'd0);
      send_word(REQ_READ, '1, '0, '0, 4'd15);
      send_word(REQ_UPSERT, '0, 8'sh80, '0, 4'd0);
      send_word(REQ_UPSERT, '1, 8'sh7F, SEEN_MAX, 4'd15);
      send_word(REQ_UPSERT, '0, 8'sh05, SEEN_MAX, 4'd7);
      send_word(REQ_READ, random_key(), '0, '0, 4'd0);
      send_word(REQ_READ, random_key(), '0, '0, 4'd2);

      // fill to capacity with every timestamp at max
      for (int i = 2; i < TABLE_ENTRIES; i++) begin
         send_word(REQ_UPSERT, 48'hAAAA_AAAA_0000 | KEY_W'(i), STR_W'(i), SEEN_MAX,
                   SLOT_W'(i));
      end

      // all-max tie evicts index 0; read back both ends
      send_word(REQ_UPSERT, 48'h5555_5555_5555, 8'shC4, 32'h0000_1000, 4'd0);
      send_word(REQ_READ, random_key(), '0, '0, 4'd15);
      send_word(REQ_READ, random_key(), '0, '0, 4'd0);

      // random sightings over a small key pool, reads mixed in
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 60 == 0) begin
            burst = ($urandom_range(0, 2) == 0);
         end
         roll     = $urandom_range(0, 99);
         strength = STR_W'($urandom_range(0, 255));
         idx      = SLOT_W'($urandom_range(0, 15));
         // mostly a slowly advancing clock, so equal times are common
         case ($urandom_range(0, 9))
            0: now = $urandom;
            1: now = SEEN_MAX;
            2: now = '0;
            default: begin
               clock_ms = clock_ms + SEEN_W'($urandom_range(0, 3));
               now = clock_ms;
            end
         endcase
         if (roll < 25) begin
            send_word(REQ_READ, random_key(), strength, now, idx);
         end else if (roll < 85) begin
            send_word(REQ_UPSERT, key_pool[$urandom_range(0, POOL_SIZE - 1)],
                      strength, now, idx);
         end else begin
            send_word(REQ_UPSERT, random_key(), strength, now, idx);
         end
      end
      start <= 1'b0;

      // drain: the checker count is a registered value; wait until it falls to zero
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("** device_table_upsert_oldest_evict: PASSED **");
      end else begin
         $display("** device_table_upsert_oldest_evict: FAILED **");
      end
      $finish;
   end

endmodule
